>>> sv/asac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asac_pkg
// shared types and constants of the adjacent-step array counter
// ----------------------------------------------------------------------------
package asac_pkg;

    localparam int ELEM_W  = 8;
    localparam int CFG_W   = 8;
    localparam int COUNT_W = 30;
    localparam int SUM_W   = 32;

    localparam logic [COUNT_W-1:0] COUNT_MOD       = 30'd1000000007;
    localparam logic [CFG_W-1:0]   MAX_VALUE_RESET = 8'd128;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // control bundle from the sequencer to the datapath
    typedef struct packed {
        logic ready;     // waiting for an input beat
        logic sweep;     // walking the count vector
        logic mid_done;  // element done, array goes on
        logic out_load;  // last element done, total goes to the output register
    } t_ctrl;

endpackage

>>> sv/asac_mod3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asac_mod3
// registered three-input adder modulo 1e9+7, inputs already reduced
// ----------------------------------------------------------------------------
module asac_mod3
    import asac_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clr,
    input  logic               i_en,
    input  logic [COUNT_W-1:0] i_a,
    input  logic [COUNT_W-1:0] i_b,
    input  logic [COUNT_W-1:0] i_c,
    output logic [COUNT_W-1:0] o_sum
);

    localparam logic [SUM_W-1:0] MOD1 = SUM_W'(COUNT_MOD);
    localparam logic [SUM_W-1:0] MOD2 = SUM_W'(COUNT_MOD) + SUM_W'(COUNT_MOD);

    logic [SUM_W-1:0]   s_raw;
    logic [SUM_W-1:0]   s_red;
    logic [COUNT_W-1:0] r_sum;
    logic [COUNT_W-1:0] n_sum;

    // sum stays below three times the modulus, so two trial subtracts cover it
    always_comb begin
        s_raw = SUM_W'(i_a) + SUM_W'(i_b) + SUM_W'(i_c);
        if (s_raw >= MOD2) begin
            s_red = s_raw - MOD2;
        end else if (s_raw >= MOD1) begin
            s_red = s_raw - MOD1;
        end else begin
            s_red = s_raw;
        end
        n_sum = r_sum;
        if (i_clr) begin
            n_sum = '0;
        end else if (i_en) begin
            n_sum = s_red[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

>>> sv/asac_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asac_ctrl
// sequencer: one sweep over the count vector per element
// ----------------------------------------------------------------------------
module asac_ctrl
    import asac_pkg::*;
#(
    parameter int MAX_VALUE_BOUND = 128,
    parameter int CW              = $clog2(MAX_VALUE_BOUND + 1)
)
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_last,
    input  logic          i_out_free,
    output t_ctrl         o_ctrl,
    output logic [CW-1:0] o_step
);

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_step;
    logic [CW-1:0] n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_ctrl  = '0;
        case (r_state)
            ST_IDLE: begin
                o_ctrl.ready = 1'b1;
                if (i_accept) begin
                    n_state = ST_SWEEP;
                    n_step  = '0;
                end
            end
            ST_SWEEP: begin
                o_ctrl.sweep = 1'b1;
                n_step       = r_step + CW'(1);
                if (r_step == CW'(MAX_VALUE_BOUND)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!i_last) begin
                    o_ctrl.mid_done = 1'b1;
                    n_state         = ST_IDLE;
                end else if (i_out_free) begin
                    o_ctrl.out_load = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_step = r_step;

endmodule

>>> sv/adjacent_step_array_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacent_step_array_counter
// counts arrays with neighbor steps of at most one, modulo 1e9+7
// ----------------------------------------------------------------------------
// usage
//   input stream: one beat per array element; tdata[7:0] is the element
//   (0 = free entry, else the fixed value), tlast marks the final element
//   output stream: one beat per array, sent after the tlast element;
//   tdata[29:0] is the number of valid arrays modulo 1e9+7
//   config: i_cfg_wr_en writes max_value, only between elements
// timing
//   each element walks the whole count vector through one shared modular
//   adder, one entry per cycle, bounded by the single read and single
//   write port of the count memory; an element passes through accept,
//   a priming read, the sweep, drain and finish
//   o_s_tready is high only while the block waits for an element
//   the result is loaded into the output register at the finish of the tlast element
// reset
//   no array in progress, max_value = 128, output empty; the count memory
//   is not cleared, the first element of each array rewrites every entry
// stall
//   the result waits in the output register; the next array's elements are
//   taken meanwhile, only a second result waits until the first one leaves
// ----------------------------------------------------------------------------
module adjacent_step_array_counter
    import asac_pkg::*;
#(
    parameter int MAX_VALUE_BOUND = 128
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,  // max_value
    // element stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,      // [7:0] element_value
    input  logic        i_s_tlast,      // last_element
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata       // [29:0] way_count, [31:30] zero
);

    localparam int IW = $clog2(MAX_VALUE_BOUND);
    localparam int CW = $clog2(MAX_VALUE_BOUND + 1);
    localparam int VW = (CW + 1 > ELEM_W) ? CW + 1 : ELEM_W;

    // configuration register
    logic [CFG_W-1:0]   r_max_value;

    // element latched at accept
    logic [ELEM_W-1:0]  r_elem;
    logic               r_last;
    logic [VW-1:0]      r_lim;
    logic               r_started;

    // sequencer
    t_ctrl              ctrl;
    logic [CW-1:0]      step;
    logic               accept;
    logic               out_free;

    // count memory and sweep window
    logic [COUNT_W-1:0] r_mem [MAX_VALUE_BOUND];
    logic [COUNT_W-1:0] r_rdata;
    logic [COUNT_W-1:0] r_w1;     // old count one below the incoming one
    logic [COUNT_W-1:0] r_w2;     // old count two below
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic [CW:0]        step_p1;

    // shared adder inputs
    logic               add_en;
    logic [COUNT_W-1:0] add_a;
    logic [COUNT_W-1:0] add_b;
    logic [COUNT_W-1:0] add_c;
    logic [COUNT_W-1:0] new_count;
    logic [VW-1:0]      value;
    logic               allowed;
    logic [CW-1:0]      step_m1;

    // new count write-back
    logic               r_res_vld;
    logic [IW-1:0]      r_res_addr;
    logic [COUNT_W-1:0] total;

    // output register
    logic               r_out_vld;
    logic [COUNT_W-1:0] r_out_data;

    assign accept   = i_s_tvalid && ctrl.ready;
    assign out_free = !r_out_vld || i_m_tready;

    asac_ctrl #(
        .MAX_VALUE_BOUND (MAX_VALUE_BOUND),
        .CW              (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_last     (r_last),
        .i_out_free (out_free),
        .o_ctrl     (ctrl),
        .o_step     (step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value <= MAX_VALUE_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_value <= i_cfg_wr_data;
        end
    end

    // latch the element and the clamped limit for the whole sweep
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_elem <= i_s_tdata;
            r_last <= i_s_tlast;
            if (VW'(r_max_value) > VW'(MAX_VALUE_BOUND)) begin
                r_lim <= VW'(MAX_VALUE_BOUND);
            end else begin
                r_lim <= VW'(r_max_value);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
        end else if (ctrl.mid_done) begin
            r_started <= 1'b1;
        end else if (ctrl.out_load) begin
            r_started <= 1'b0;
        end
    end

    // read runs one entry ahead of the adder: entry 0 at accept, step+1 in sweep
    assign step_p1 = {1'b0, step} + (CW + 1)'(1);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (accept) begin
            rd_en = 1'b1;
        end else if (ctrl.sweep && (step_p1 < (CW + 1)'(MAX_VALUE_BOUND))) begin
            rd_en   = 1'b1;
            rd_addr = step_p1[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_res_vld) begin
            r_mem[r_res_addr] <= new_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.sweep) begin
            r_w2 <= r_w1;
            r_w1 <= r_rdata;
        end
    end

    // at step j the adder produces the count for value j (entry j-1)
    assign value   = VW'(step);
    assign step_m1 = step - CW'(1);
    assign allowed = (value <= r_lim)
                  && ((r_elem == '0) || (VW'(r_elem) == value));
    assign add_en  = ctrl.sweep && (step != '0);

    always_comb begin
        add_a = '0;
        add_b = '0;
        add_c = '0;
        if (allowed) begin
            if (!r_started) begin
                // first element: every allowed value starts at one
                add_a = COUNT_W'(1);
            end else begin
                add_a = r_w1;
                if (step >= CW'(2)) begin
                    add_b = r_w2;
                end
                if (value + VW'(1) <= r_lim) begin
                    add_c = r_rdata;
                end
            end
        end
    end

    asac_mod3 u_step_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (1'b0),
        .i_en    (add_en),
        .i_a     (add_a),
        .i_b     (add_b),
        .i_c     (add_c),
        .o_sum   (new_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= add_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (add_en) begin
            r_res_addr <= step_m1[IW-1:0];
        end
    end

    // running total of the new counts, cleared on each element
    asac_mod3 u_total_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (accept),
        .i_en    (r_res_vld),
        .i_a     (total),
        .i_b     (new_count),
        .i_c     ('0),
        .o_sum   (total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_out_data <= total;
        end
    end

    assign o_s_tready = ctrl.ready;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {2'b00, r_out_data};

endmodule

>>> sv/asac_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asac_checker
// port-level checks of the adjacent-step array counter
// ----------------------------------------------------------------------------
module asac_checker
    import asac_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    // an element occupies the block, it drops ready right after the beat
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("ready still high after an element beat");

    // a result is loaded only at the end of a sweep, never while idle
    a_result_from_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result appeared without a finished sweep");

    // counts stay reduced
    a_count_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata < 32'(COUNT_MOD)))
        else $error("result not reduced modulo 1e9+7");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind adjacent_step_array_counter asac_checker u_asac_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
